// File: rtl/broadcast_date_time_decoder_defines.svh
// Assertion macros used by the checker file of the date and time decoder.
`ifndef BROADCAST_DATE_TIME_DECODER_DEFINES_SVH
`define BROADCAST_DATE_TIME_DECODER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define BDT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bdt_pkg.sv
// Package of the date and time decoder: widths, calendar constants, microcode.
package bdt_pkg;

    localparam int MJD_W   = 17;
    localparam int X_W     = 18;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int ZH_W    = 5;
    localparam int ZM_W    = 5;
    localparam int OFS_W   = 4;
    localparam int W_W     = 9;
    localparam int PC_W    = 5;

    localparam int JD_OFFSET  = 2400001;
    localparam int JDN_BIAS   = 32044;
    localparam int DAYS_400Y  = 146097;
    localparam int DAYS_100Y  = 36524;
    localparam int DAYS_4Y    = 1461;
    localparam int DAYS_1Y    = 365;
    localparam int MONTH_BIAS = 308;
    localparam int MONTH_DIV  = 153;
    localparam int YEAR_BIAS  = 4800;
    localparam int DAY_DIV    = 5;
    // every 17-bit day number lies in 400-year era 16 or 17
    localparam int ERA_BASE   = 16;

    localparam logic [X_W-1:0] X_START =
        X_W'(JD_OFFSET + JDN_BIAS - ERA_BASE * DAYS_400Y);
    localparam logic [YEAR_W-1:0] Y_START = YEAR_W'(ERA_BASE * 400 - YEAR_BIAS);
    localparam logic [ZM_W-1:0] HALF_HOUR = ZM_W'(30);

    localparam logic OPC_ZONE = 1'b0;
    localparam logic OPC_TIME = 1'b1;

    typedef enum logic {
        OP_CSUB = 1'b0,   // subtract k if it fits, then add w to dest
        OP_MUL5 = 1'b1    // x = 5x + month bias
    } t_op;

    typedef enum logic [1:0] {
        DST_Y = 2'd0,
        DST_M = 2'd1,
        DST_D = 2'd2
    } t_dest;

    typedef struct packed {
        t_op              op;
        t_dest            dest;
        logic [X_W-1:0]   k;
        logic [W_W-1:0]   w;
        logic             jump_on_fail;
        logic [PC_W-1:0]  target;
        logic             last;
    } t_uword;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic run;
        logic finish;
    } t_seq_status;

    // jump targets
    localparam logic [PC_W-1:0] PC_QUAD  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_SCALE = PC_W'(12);

    function automatic t_uword uop(input t_op op, input t_dest dst, input int k,
                                   input int w, input logic jf, input logic [PC_W-1:0] tgt,
                                   input logic last);
        t_uword uw;
        uw.op           = op;
        uw.dest         = dst;
        uw.k            = X_W'(k);
        uw.w            = W_W'(w);
        uw.jump_on_fail = jf;
        uw.target       = tgt;
        uw.last         = last;
        return uw;
    endfunction

    // Conversion program: the quotients are built by conditional subtraction,
    // weighted straight into year, month and day.
    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword uw;
        unique case (pc)
            5'd0:  uw = uop(OP_CSUB, DST_Y, DAYS_400Y, 400, 1'b0, '0, 1'b0);
            5'd1:  uw = uop(OP_CSUB, DST_Y, DAYS_100Y, 100, 1'b1, PC_QUAD, 1'b0);
            5'd2:  uw = uop(OP_CSUB, DST_Y, DAYS_100Y, 100, 1'b1, PC_QUAD, 1'b0);
            5'd3:  uw = uop(OP_CSUB, DST_Y, DAYS_100Y, 100, 1'b0, '0, 1'b0);
            5'd4:  uw = uop(OP_CSUB, DST_Y, DAYS_4Y * 16, 64, 1'b0, '0, 1'b0);
            5'd5:  uw = uop(OP_CSUB, DST_Y, DAYS_4Y * 8, 32, 1'b0, '0, 1'b0);
            5'd6:  uw = uop(OP_CSUB, DST_Y, DAYS_4Y * 4, 16, 1'b0, '0, 1'b0);
            5'd7:  uw = uop(OP_CSUB, DST_Y, DAYS_4Y * 2, 8, 1'b0, '0, 1'b0);
            5'd8:  uw = uop(OP_CSUB, DST_Y, DAYS_4Y, 4, 1'b0, '0, 1'b0);
            5'd9:  uw = uop(OP_CSUB, DST_Y, DAYS_1Y, 1, 1'b1, PC_SCALE, 1'b0);
            5'd10: uw = uop(OP_CSUB, DST_Y, DAYS_1Y, 1, 1'b1, PC_SCALE, 1'b0);
            5'd11: uw = uop(OP_CSUB, DST_Y, DAYS_1Y, 1, 1'b0, '0, 1'b0);
            5'd12: uw = uop(OP_MUL5, DST_Y, 0, 0, 1'b0, '0, 1'b0);
            // January and February belong to the next calendar year
            5'd13: uw = uop(OP_CSUB, DST_Y, MONTH_DIV * 12, 1, 1'b0, '0, 1'b0);
            5'd14: uw = uop(OP_CSUB, DST_M, MONTH_DIV * 8, 8, 1'b0, '0, 1'b0);
            5'd15: uw = uop(OP_CSUB, DST_M, MONTH_DIV * 4, 4, 1'b0, '0, 1'b0);
            5'd16: uw = uop(OP_CSUB, DST_M, MONTH_DIV * 2, 2, 1'b0, '0, 1'b0);
            5'd17: uw = uop(OP_CSUB, DST_M, MONTH_DIV, 1, 1'b0, '0, 1'b0);
            // day of month is the month remainder over five
            5'd18: uw = uop(OP_CSUB, DST_D, DAY_DIV * 16, 16, 1'b0, '0, 1'b0);
            5'd19: uw = uop(OP_CSUB, DST_D, DAY_DIV * 8, 8, 1'b0, '0, 1'b0);
            5'd20: uw = uop(OP_CSUB, DST_D, DAY_DIV * 4, 4, 1'b0, '0, 1'b0);
            5'd21: uw = uop(OP_CSUB, DST_D, DAY_DIV * 2, 2, 1'b0, '0, 1'b0);
            5'd22: uw = uop(OP_CSUB, DST_D, DAY_DIV, 1, 1'b0, '0, 1'b1);
            default: uw = uop(OP_CSUB, DST_D, 0, 0, 1'b0, '0, 1'b1);
        endcase
        return uw;
    endfunction

endpackage

// File: rtl/bdt_if.sv
// Valid/ready channel interfaces for the decoder's input and result items.
interface bdt_in_if import bdt_pkg::*;;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic              offset_negative;
    logic [OFS_W-1:0]  offset_hours;
    logic              offset_half_hour;
    logic [MJD_W-1:0]  day_number;
    logic              has_seconds;
    logic [HOUR_W-1:0] hour_field;
    logic [MIN_W-1:0]  minute_field;
    logic [SEC_W-1:0]  second_field;

    modport source (
        output valid, opcode, offset_negative, offset_hours, offset_half_hour,
               day_number, has_seconds, hour_field, minute_field, second_field,
        input  ready
    );
    modport sink (
        input  valid, opcode, offset_negative, offset_hours, offset_half_hour,
               day_number, has_seconds, hour_field, minute_field, second_field,
        output ready
    );
endinterface

interface bdt_out_if import bdt_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [YEAR_W-1:0]      year;
    logic [MONTH_W-1:0]     month;
    logic [DAY_W-1:0]       day;
    logic [HOUR_W-1:0]      hour;
    logic [MIN_W-1:0]       minute;
    logic [SEC_W-1:0]       second;
    logic signed [ZH_W-1:0] zone_hours;
    logic [ZM_W-1:0]        zone_minutes;

    modport source (
        output valid, year, month, day, hour, minute, second, zone_hours,
               zone_minutes,
        input  ready
    );
    modport sink (
        input  valid, year, month, day, hour, minute, second, zone_hours,
               zone_minutes,
        output ready
    );
endinterface

// File: rtl/broadcast_date_time_decoder.sv
// Broadcast date and time decoder, top level.
// A zone item only updates the stored zone offset and marks a zone as seen.
// A time item updates minute and seconds tracking at once, then runs a
// microprogram of 19 to 23 steps on one shared subtractor that turns the
// modified Julian day into year, month and day; the decoder is ready for the
// next item once the microprogram has ended, or later if the previous
// result has not yet been taken. A result is produced only after a
// zone item has been received; the zone fields show the offset at the time
// the time item was accepted.
module broadcast_date_time_decoder import bdt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdt_in_if.sink    i_in,
    bdt_out_if.source o_out
);

    logic                   w_accept, w_start, w_release, w_fail;
    t_uword                 w_uword;
    t_seq_status            w_status;
    logic [YEAR_W-1:0]      w_year;
    logic [MONTH_W-1:0]     w_month;
    logic [DAY_W-1:0]       w_day;

    logic                   r_zone_seen;
    logic signed [ZH_W-1:0] r_zone_hours;
    logic [ZM_W-1:0]        r_zone_minutes;
    logic [MIN_W-1:0]       r_last_minute;
    logic [SEC_W-1:0]       r_held_second;
    logic                   r_emit;
    logic [HOUR_W-1:0]      r_hour;

    logic                   r_out_valid;
    logic [YEAR_W-1:0]      r_out_year;
    logic [MONTH_W-1:0]     r_out_month;
    logic [DAY_W-1:0]       r_out_day;
    logic [HOUR_W-1:0]      r_out_hour;
    logic [MIN_W-1:0]       r_out_minute;
    logic [SEC_W-1:0]       r_out_second;
    logic signed [ZH_W-1:0] r_out_zone_hours;
    logic [ZM_W-1:0]        r_out_zone_minutes;

    assign i_in.ready = !w_status.busy;
    assign w_accept   = i_in.valid && !w_status.busy;
    assign w_start    = w_accept && (i_in.opcode == OPC_TIME);
    assign w_release  = !r_emit || !r_out_valid || o_out.ready;

    bdt_sequencer u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_fail    (w_fail),
        .i_release (w_release),
        .o_uword   (w_uword),
        .o_status  (w_status)
    );

    bdt_datapath u_dp (
        .i_clk        (i_clk),
        .i_start      (w_start),
        .i_day_number (i_in.day_number),
        .i_run        (w_status.run),
        .i_uword      (w_uword),
        .o_fail       (w_fail),
        .o_year       (w_year),
        .o_month      (w_month),
        .o_day        (w_day)
    );

    // zone and seconds tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_seen    <= 1'b0;
            r_zone_hours   <= '0;
            r_zone_minutes <= '0;
            r_last_minute  <= '0;
            r_held_second  <= '0;
            r_emit         <= 1'b0;
        end else if (w_accept) begin
            if (i_in.opcode == OPC_ZONE) begin
                // a negative zero offset stores zero
                r_zone_hours   <= i_in.offset_negative ? ZH_W'(0) - {1'b0, i_in.offset_hours}
                                                       : {1'b0, i_in.offset_hours};
                r_zone_minutes <= i_in.offset_half_hour ? HALF_HOUR : '0;
                r_zone_seen    <= 1'b1;
            end else begin
                r_last_minute <= i_in.minute_field;
                if (i_in.has_seconds) begin
                    r_held_second <= i_in.second_field;
                end else if (i_in.minute_field != r_last_minute) begin
                    r_held_second <= '0;
                end
                r_emit <= r_zone_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_hour <= i_in.hour_field;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_status.finish && r_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_status.finish && r_emit) begin
            r_out_year         <= w_year;
            r_out_month        <= w_month;
            r_out_day          <= w_day;
            r_out_hour         <= r_hour;
            r_out_minute       <= r_last_minute;
            r_out_second       <= r_held_second;
            r_out_zone_hours   <= r_zone_hours;
            r_out_zone_minutes <= r_zone_minutes;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.year         = r_out_year;
    assign o_out.month        = r_out_month;
    assign o_out.day          = r_out_day;
    assign o_out.hour         = r_out_hour;
    assign o_out.minute       = r_out_minute;
    assign o_out.second       = r_out_second;
    assign o_out.zone_hours   = r_out_zone_hours;
    assign o_out.zone_minutes = r_out_zone_minutes;

endmodule

// File: rtl/bdt_sequencer.sv
// Microcode sequencer: step counter, control store fetch and conditional jumps.
module bdt_sequencer import bdt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_fail,
    input  logic        i_release,
    output t_uword      o_uword,
    output t_seq_status o_status
);

    t_seq_state      r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          w_uw;

    assign w_uw    = ucode_rom(r_pc);
    assign o_uword = w_uw;

    assign o_status.busy   = (r_state != ST_IDLE);
    assign o_status.run    = (r_state == ST_RUN);
    assign o_status.finish = (r_state == ST_DONE) && i_release;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_pc    = '0;
                end
            end
            ST_RUN: begin
                if (w_uw.last) begin
                    n_state = ST_DONE;
                end else if (w_uw.jump_on_fail && i_fail) begin
                    n_pc = w_uw.target;
                end else begin
                    n_pc = r_pc + PC_W'(1);
                end
            end
            ST_DONE: begin
                if (i_release) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule

// File: rtl/bdt_datapath.sv
// Conversion datapath: remainder register, one subtractor and the date accumulators.
module bdt_datapath import bdt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_start,
    input  logic [MJD_W-1:0]   i_day_number,
    input  logic               i_run,
    input  t_uword             i_uword,
    output logic               o_fail,
    output logic [YEAR_W-1:0]  o_year,
    output logic [MONTH_W-1:0] o_month,
    output logic [DAY_W-1:0]   o_day
);

    logic [X_W-1:0]     r_x;
    logic [YEAR_W-1:0]  r_y;
    logic [MONTH_W-1:0] r_m;
    logic [DAY_W-1:0]   r_d;
    logic [X_W:0]       w_diff;
    logic               w_fits;
    logic [X_W+2:0]     w_scaled;

    assign w_diff   = {1'b0, r_x} - {1'b0, i_uword.k};
    assign w_fits   = !w_diff[X_W];
    assign w_scaled = {1'b0, r_x, 2'b00} + {3'b000, r_x} + (X_W+3)'(MONTH_BIAS);
    assign o_fail   = (i_uword.op == OP_CSUB) && !w_fits;

    assign o_year  = r_y;
    assign o_month = r_m;
    assign o_day   = r_d;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= X_START + X_W'(i_day_number);
            r_y <= Y_START;
            r_m <= MONTH_W'(1);
            r_d <= DAY_W'(1);
        end else if (i_run) begin
            case (i_uword.op)
                OP_CSUB: begin
                    if (w_fits) begin
                        r_x <= w_diff[X_W-1:0];
                        unique case (i_uword.dest)
                            DST_Y:   r_y <= r_y + YEAR_W'(i_uword.w);
                            DST_M:   r_m <= r_m + i_uword.w[MONTH_W-1:0];
                            DST_D:   r_d <= r_d + i_uword.w[DAY_W-1:0];
                            default: ;
                        endcase
                    end
                end
                OP_MUL5: r_x <= w_scaled[X_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/bdt_checker.sv
// Port-level checker for the date and time decoder, bound to the top level.
`include "broadcast_date_time_decoder_defines.svh"

module bdt_checker import bdt_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_opcode,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [MONTH_W-1:0] i_out_month,
    input logic [DAY_W-1:0]   i_out_day
);

    logic r_zone_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_seen <= 1'b0;
        end else if (i_in_valid && i_in_ready && (i_in_opcode == OPC_ZONE)) begin
            r_zone_seen <= 1'b1;
        end
    end

    `BDT_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped before transfer")
    `BDT_ASSERT(a_zone_first, i_clk, i_rst_n, i_out_valid |-> r_zone_seen, "result before any zone item")
    `BDT_ASSERT(a_date_range, i_clk, i_rst_n, i_out_valid |-> (i_out_month >= 4'd1 && i_out_month <= 4'd12 && i_out_day != 5'd0), "month or day out of range")
    `BDT_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!i_out_valid && i_in_ready), "not idle after reset")

endmodule

bind broadcast_date_time_decoder bdt_checker u_bdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_opcode (i_in.opcode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_month (o_out.month),
    .i_out_day   (o_out.day)
);
